>>> rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every rising clock edge, quiet while reset is asserted
`define DNLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising clock edge, also during reset
`define DNLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DNLE_ASSERT(lbl, prop, msg)
`define DNLE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/core/dnle_pkg.sv
`default_nettype none

package dnle_pkg;

    localparam int LABEL_MAX  = 63;
    localparam int NAME_BYTES = 256;

    localparam int CNT_W = $clog2(LABEL_MAX + 1);
    localparam int IDX_W = $clog2(LABEL_MAX);
    localparam int POS_W = $clog2(NAME_BYTES + 1);

    localparam logic [7:0] CHAR_END = 8'h00;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LABEL_LONG = 2'd1;
    localparam logic [1:0] ST_NAME_OVF   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic start;
        logic drop;
        logic emit_len;
        logic emit_chr;
        logic emit_fin;
    } dnle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_end;
        logic is_dot;
        logic err_any;
        logic cnt_zero;
        logic wp_full;
        logic wp_edge;
        logic chr_last;
        logic end_flag;
        logic out_free;
    } dnle_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/dns_name_label_encoder.sv
`default_nettype none

// Encodes a dotted domain name, one character per request, into DNS wire format.
// A character of 0 ends the name and 0x2E separates labels. An ordinary character
// is taken and stored in a 63-entry label buffer. At a dot or at the end the held
// label of n characters goes out as a length byte and n character bytes, each with
// its position; each character is read from the buffer (separate write and read
// ports, registered read) and then sent. The consumer can hold back the output,
// which stalls the sending. While a label is sent no character is taken. The end
// marker always gives a result with name_done and the final status (0 ok, 1 label
// too long, 2 name exceeds 256 bytes); the terminating zero and padding are left
// to the consumer. After an error, characters up to the end are dropped.
// Output: tdata[7:0] byte, [15:8] position, [16] name_done, [18:17] status;
// tuser is has_byte, tlast marks the last result of a request.

module dns_name_label_encoder
    import dnle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // ch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_byte, out_pos, name_done, status
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // has_byte
);

    dnle_cmd_t  cmd;
    dnle_stat_t st;

    logic [7:0] out_byte;
    logic [7:0] out_pos;
    logic       out_name_done;
    logic [1:0] out_status;

    dnle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dnle_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ch            (s_axis_tdata),
        .cmd           (cmd),
        .st            (st),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_has_byte  (m_axis_tuser),
        .out_byte      (out_byte),
        .out_pos       (out_pos),
        .out_run_last  (m_axis_tlast),
        .out_name_done (out_name_done),
        .out_status    (out_status)
    );

    assign m_axis_tdata = {5'd0, out_status, out_name_done, out_pos, out_byte};

endmodule

`default_nettype wire

>>> rtl/core/dnle_ram.sv
`default_nettype none

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/dnle_ctrl.sv
`default_nettype none

module dnle_ctrl
    import dnle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dnle_stat_t st,
    output dnle_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_WAIT,
        S_CHR,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.is_end)
                    begin
                        cmd.start = 1'b1;
                        if (!st.err_any && !st.cnt_zero)
                        begin
                            state_next = S_LEN;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (st.err_any)
                    begin
                        // dropped until the end of the name
                        state_next = S_IDLE;
                    end
                    else if (st.is_dot)
                    begin
                        if (!st.cnt_zero)
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_LEN;
                        end
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                if (st.out_free)
                begin
                    if (st.wp_full)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = st.end_flag ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_len = 1'b1;
                        state_next   = st.wp_edge ? S_IDLE : S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                // wait for the registered buffer read
                state_next = S_CHR;
            end
            S_CHR:
            begin
                if (st.out_free)
                begin
                    cmd.emit_chr = 1'b1;
                    state_next   = (st.chr_last || st.wp_edge) ? S_IDLE : S_WAIT;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.emit_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dnle_dp.sv
`default_nettype none

`include "assert_macros.svh"

module dnle_dp
    import dnle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] ch,
    input  wire dnle_cmd_t  cmd,
    output dnle_stat_t      st,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic            out_has_byte,
    output logic [7:0]      out_byte,
    output logic [7:0]      out_pos,
    output logic            out_run_last,
    output logic            out_name_done,
    output logic [1:0]      out_status
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] wp_reg, wp_next;
    logic [1:0]       err_reg, err_next;
    logic             valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             end_reg, end_next;

    logic             has_reg, has_next;
    logic [7:0]       byte_reg, byte_next;
    logic [7:0]       pos_reg, pos_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;

    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic             count_full;
    logic             emit;
    logic             last_now;
    logic [POS_W-1:0] wp_inc;

    dnle_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_MAX)
    ) u_label_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ch),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign count_full = (count_reg >= CNT_W'(LABEL_MAX));
    assign wp_inc     = wp_reg + POS_W'(1);
    assign emit       = cmd.emit_len | cmd.emit_chr | cmd.emit_fin;

    assign st.is_end   = (ch == CHAR_END);
    assign st.is_dot   = (ch == CHAR_DOT);
    assign st.err_any  = (err_reg != ST_OK);
    assign st.cnt_zero = (count_reg == '0);
    assign st.wp_full  = (wp_reg >= POS_W'(NAME_BYTES));
    // one more byte fits, the one after it does not
    assign st.wp_edge  = (wp_reg == POS_W'(NAME_BYTES - 1));
    assign st.chr_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign st.end_flag = end_reg;
    assign st.out_free = !valid_reg || out_ready;

    always_comb
    begin
        count_next  = count_reg;
        wp_next     = wp_reg;
        err_next    = err_reg;
        idx_next    = idx_reg;
        end_next    = end_reg;
        ram_we      = 1'b0;
        last_now    = 1'b0;
        has_next    = has_reg;
        byte_next   = byte_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        status_next = status_reg;

        if (cmd.store)
        begin
            if (count_full)
            begin
                err_next   = ST_LABEL_LONG;
                count_next = '0;
            end
            else
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.start)
        begin
            idx_next = '0;
            end_next = st.is_end;
        end

        if (cmd.drop)
        begin
            err_next   = ST_NAME_OVF;
            count_next = '0;
        end

        if (cmd.emit_len)
        begin
            last_now    = st.wp_edge;
            has_next    = 1'b1;
            byte_next   = 8'(count_reg);
            pos_next    = wp_reg[7:0];
            last_next   = last_now;
            done_next   = last_now && end_reg;
            status_next = (last_now && end_reg) ? ST_NAME_OVF : ST_OK;
            wp_next     = wp_inc;
            if (last_now)
            begin
                if (end_reg)
                begin
                    count_next = '0;
                    wp_next    = '0;
                    err_next   = ST_OK;
                end
                else
                begin
                    err_next   = ST_NAME_OVF;
                    count_next = '0;
                end
            end
        end

        if (cmd.emit_chr)
        begin
            last_now    = st.chr_last || st.wp_edge;
            has_next    = 1'b1;
            byte_next   = ram_rdata;
            pos_next    = wp_reg[7:0];
            last_next   = last_now;
            done_next   = last_now && end_reg;
            status_next = (last_now && end_reg && st.wp_edge) ? ST_NAME_OVF : ST_OK;
            wp_next     = wp_inc;
            idx_next    = idx_reg + IDX_W'(1);
            if (last_now)
            begin
                if (end_reg)
                begin
                    count_next = '0;
                    wp_next    = '0;
                    err_next   = ST_OK;
                end
                else
                begin
                    count_next = '0;
                    if (st.wp_edge && !st.chr_last)
                    begin
                        err_next = ST_NAME_OVF;
                    end
                end
            end
        end

        if (cmd.emit_fin)
        begin
            has_next    = 1'b0;
            byte_next   = '0;
            pos_next    = '0;
            last_next   = 1'b1;
            done_next   = 1'b1;
            // no room left for the terminating zero
            if (err_reg != ST_OK)
            begin
                status_next = err_reg;
            end
            else if (st.wp_full)
            begin
                status_next = ST_NAME_OVF;
            end
            else
            begin
                status_next = ST_OK;
            end
            count_next = '0;
            wp_next    = '0;
            err_next   = ST_OK;
        end

        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wp_reg    <= '0;
            err_reg   <= ST_OK;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wp_reg    <= wp_next;
            err_reg   <= err_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        has_reg    <= has_next;
        byte_reg   <= byte_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

    assign out_valid     = valid_reg;
    assign out_has_byte  = has_reg;
    assign out_byte      = byte_reg;
    assign out_pos       = pos_reg;
    assign out_run_last  = last_reg;
    assign out_name_done = done_reg;
    assign out_status    = status_reg;

    `DNLE_ASSERT(a_count_range, count_reg <= CNT_W'(LABEL_MAX), "label count out of range")
    `DNLE_ASSERT(a_wp_range, wp_reg <= POS_W'(NAME_BYTES), "write position out of range")
    `DNLE_ASSERT(a_err_clears_label, (err_reg != ST_OK) |-> (count_reg == '0), "label kept")
    // drop and the three emit commands
    `DNLE_ASSERT_ALWAYS(a_one_emit, $onehot0(cmd[3:0]), "conflicting output commands")
    `DNLE_ASSERT(a_emit_when_free, emit |-> (!valid_reg || out_ready), "result overwritten")
    `DNLE_ASSERT(a_done_is_last, (valid_reg && done_reg) |-> last_reg, "name end without run end")

endmodule

`default_nettype wire

>>> bench/dns_name_label_encoder_tb.sv
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int RAND_ITEMS = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int SHOW_MAX = 10;

    typedef struct packed {
        logic       has;
        logic [7:0] b;
        logic [7:0] pos;
        logic       last;
        logic       done;
        logic [1:0] st;
    } wire_byte_t;

    typedef struct {
        logic [7:0] ch;
        int         rep;
        bit         fixed;
        wire_byte_t res;
    } char_row_t;

    typedef struct {
        int         idx;
        wire_byte_t res;
    } fixed_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    dns_name_label_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // encoder model state
    logic [7:0] lbl_buf [LABEL_MAX];
    logic [6:0] lbl_cnt;
    logic [8:0] wr_pos;
    logic [1:0] err_st;

    wire_byte_t  new_bytes[$];
    wire_byte_t  wire_q[$];
    fixed_byte_t fixed_q[$];
    char_row_t   char_rows[$];

    int sent_items;
    int acc_idx;
    int burst_left;
    int fail_cnt;
    int byte_cnt;
    int name_cnt;
    int long_cnt;
    int ovf_cnt;
    int cycles = 0;
    int rhold = 0;
    logic [1:0]  rmode = 2'd0;
    logic [15:0] rcyc = '0;
    wire_byte_t  got;
    wire_byte_t  want;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic emit_label();
        int j;
        wire_byte_t r;
        begin
            j = 0;
            while (j <= lbl_cnt)
            begin
                if (wr_pos >= NAME_BYTES)
                begin
                    err_st = ST_NAME_OVF;
                    j = lbl_cnt + 1;
                end
                else
                begin
                    r = '0;
                    r.has = 1'b1;
                    r.b = (j == 0) ? {1'b0, lbl_cnt} : lbl_buf[j - 1];
                    r.pos = wr_pos[7:0];
                    new_bytes.push_back(r);
                    wr_pos = wr_pos + 1'b1;
                    j++;
                end
            end
            lbl_cnt = '0;
        end
    endtask

    task automatic encode_char(input logic [7:0] ch);
        wire_byte_t r;
        begin
            new_bytes.delete();
            if (ch == CHAR_END)
            begin
                if (err_st == ST_OK && lbl_cnt != 0)
                    emit_label();
                // no room left for the terminating zero
                if (err_st == ST_OK && wr_pos >= NAME_BYTES)
                    err_st = ST_NAME_OVF;
                if (new_bytes.size() == 0)
                    r = '0;
                else
                    r = new_bytes.pop_back();
                r.last = 1'b1;
                r.done = 1'b1;
                r.st = err_st;
                new_bytes.push_back(r);
                lbl_cnt = '0;
                wr_pos = '0;
                err_st = ST_OK;
            end
            else if (err_st != ST_OK)
            begin
                // dropped until the end marker
            end
            else if (ch == CHAR_DOT)
            begin
                if (lbl_cnt != 0)
                    emit_label();
                if (new_bytes.size() != 0)
                begin
                    r = new_bytes.pop_back();
                    r.last = 1'b1;
                    new_bytes.push_back(r);
                end
            end
            else if (lbl_cnt >= LABEL_MAX)
            begin
                err_st = ST_LABEL_LONG;
                lbl_cnt = '0;
            end
            else
            begin
                lbl_buf[lbl_cnt] = ch;
                lbl_cnt = lbl_cnt + 1'b1;
            end
        end
    endtask

    function automatic wire_byte_t end_byte(input logic [1:0] st);
        wire_byte_t r;
        begin
            r = '0;
            r.last = 1'b1;
            r.done = 1'b1;
            r.st = st;
            return r;
        end
    endfunction

    // any character but the end marker and the separator
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        begin
            c = 8'($urandom_range(1, 254));
            if (c >= CHAR_DOT)
                c = c + 1'b1;
            return c;
        end
    endfunction

    task automatic plan(input logic [7:0] ch, input int rep);
        char_row_t row;
        begin
            row.ch = ch;
            row.rep = rep;
            row.fixed = 1'b0;
            row.res = '0;
            char_rows.push_back(row);
        end
    endtask

    task automatic plan_end(input logic [1:0] st);
        char_row_t row;
        begin
            row.ch = CHAR_END;
            row.rep = 1;
            row.fixed = 1'b1;
            row.res = end_byte(st);
            char_rows.push_back(row);
        end
    endtask

    task automatic note_fail(input string what, input wire_byte_t w, input wire_byte_t g);
        begin
            fail_cnt++;
            if (fail_cnt <= SHOW_MAX)
            begin
                $display("%s: expected has=%0d byte=%02h pos=%0d last=%0d done=%0d st=%0d",
                    what, w.has, w.b, w.pos, w.last, w.done, w.st);
                $display("    got has=%0d byte=%02h pos=%0d last=%0d done=%0d st=%0d",
                    g.has, g.b, g.pos, g.last, g.done, g.st);
            end
        end
    endtask

    task automatic send_char(input logic [7:0] ch);
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= ch;
            sent_items++;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            burst_left--;
        end
    endtask

    // hold off until every byte of the names sent so far is out
    task automatic drain_wait();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (wire_q.size() != 0)
                @(posedge clk);
            burst_left = 0;
        end
    endtask

    task automatic random_name();
        int mode;
        int nl;
        int len;
        int k;
        int total;
        int target;
        begin
            mode = $urandom_range(0, 23);
            if (mode == 0)
            begin
                // long names run into the end of the buffer
                target = $urandom_range(230, 300);
                total = 0;
                while (total < target)
                begin
                    len = $urandom_range(40, 63);
                    repeat (len) send_char(label_char());
                    send_char(CHAR_DOT);
                    total += len + 1;
                end
            end
            else if (mode == 1)
            begin
                repeat ($urandom_range(1, 8)) send_char(label_char());
                send_char(CHAR_DOT);
                repeat ($urandom_range(64, 66)) send_char(label_char());
                if ($urandom_range(0, 1) == 1)
                    send_char(CHAR_DOT);
            end
            else if (mode <= 4)
            begin
                repeat ($urandom_range(1, 16))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_char(CHAR_DOT);
                    else
                        send_char(8'($urandom_range(1, 255)));
                end
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    send_char(CHAR_DOT);
                nl = $urandom_range(1, 5);
                for (k = 0; k < nl; k++)
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 63)
                                                       : $urandom_range(1, 10);
                    repeat (len) send_char(label_char());
                    if (k < nl - 1 || $urandom_range(0, 3) == 0)
                        send_char(CHAR_DOT);
                    if ($urandom_range(0, 9) == 0)
                        send_char(CHAR_DOT);
                end
            end
            send_char(CHAR_END);
        end
    endtask

    // receiver stall pattern, mode picked anew at random whenever the low seven bits of rcyc are zero
    always @(posedge clk)
    begin
        rcyc <= rcyc + 1'b1;
        if (rcyc[6:0] == 7'd0)
            rmode <= 2'($urandom_range(0, 3));
        case (rmode)
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (rcyc[1:0] == 2'd0);
            default:
            begin
                if (rhold == 0)
                begin
                    m_axis_tready <= ~m_axis_tready;
                    rhold <= $urandom_range(0, 12);
                end
                else
                begin
                    rhold <= rhold - 1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                encode_char(s_axis_tdata);
                if (fixed_q.size() != 0 && fixed_q[0].idx == acc_idx)
                begin
                    wire_q.push_back(fixed_q[0].res);
                    fixed_q.pop_front();
                end
                else
                begin
                    foreach (new_bytes[i])
                        wire_q.push_back(new_bytes[i]);
                end
                acc_idx++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.has = m_axis_tuser;
                got.b = m_axis_tdata[7:0];
                got.pos = m_axis_tdata[15:8];
                got.last = m_axis_tlast;
                got.done = m_axis_tdata[16];
                got.st = m_axis_tdata[18:17];
                if (wire_q.size() == 0)
                begin
                    note_fail("unexpected result", '0, got);
                end
                else
                begin
                    want = wire_q.pop_front();
                    if (got.has !== want.has || got.b !== want.b || got.pos !== want.pos
                        || got.last !== want.last || got.done !== want.done
                        || got.st !== want.st)
                        note_fail("mismatch", want, got);
                end
                if (got.has === 1'b1)
                    byte_cnt++;
                if (got.done === 1'b1)
                begin
                    name_cnt++;
                    if (got.st === ST_LABEL_LONG)
                        long_cnt++;
                    if (got.st === ST_NAME_OVF)
                        ovf_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, wire_q.size());
            $display("dns_name_label_encoder_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int base;
        int k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        lbl_cnt = '0;
        wr_pos = '0;
        err_st = ST_OK;
        sent_items = 0;
        acc_idx = 0;
        burst_left = 0;
        fail_cnt = 0;
        byte_cnt = 0;
        name_cnt = 0;
        long_cnt = 0;
        ovf_cnt = 0;

        // empty name right after reset, then extreme characters and empty labels
        plan_end(ST_OK);
        plan(CHAR_DOT, 1);
        plan(8'h01, 1);
        plan(8'hFF, 1);
        plan(8'h2D, 1);
        plan(8'h2F, 1);
        plan(CHAR_DOT, 1);
        plan(CHAR_DOT, 1);
        plan(8'h80, 1);
        plan(8'h7F, 1);
        plan(CHAR_END, 1);
        plan(CHAR_DOT, 1);
        plan(CHAR_DOT, 1);
        plan_end(ST_OK);
        // longest label that fits, then one char too many
        plan(8'h61, 63);
        plan(CHAR_DOT, 1);
        plan(8'h62, 64);
        plan(8'h63, 2);
        plan(CHAR_DOT, 1);
        plan_end(ST_LABEL_LONG);
        // fill the buffer exactly, no room for the terminator
        for (k = 0; k < 4; k++)
        begin
            plan(8'(8'h41 + k), 63);
            plan(CHAR_DOT, 1);
        end
        plan_end(ST_NAME_OVF);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (char_rows[i])
        begin
            if (char_rows[i].fixed)
                fixed_q.push_back('{sent_items, char_rows[i].res});
            repeat (char_rows[i].rep) send_char(char_rows[i].ch);
        end
        drain_wait();

        base = sent_items;
        while (sent_items - base < RAND_ITEMS)
        begin
            random_name();
            if ($urandom_range(0, 7) == 0)
                drain_wait();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (wire_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d characters, checked %0d bytes over %0d names", sent_items,
            byte_cnt, name_cnt);
        $display("names ending in label too long: %0d, in buffer overflow: %0d, mismatches: %0d",
            long_cnt, ovf_cnt, fail_cnt);
        if (fail_cnt == 0 && wire_q.size() == 0)
            $display("dns_name_label_encoder_tb OK");
        else
            $display("dns_name_label_encoder_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dnle_pkg.sv
rtl/core/dnle_ram.sv
rtl/core/dnle_ctrl.sv
rtl/core/dnle_dp.sv
rtl/core/dns_name_label_encoder.sv
bench/dns_name_label_encoder_tb.sv
